// ===== hdl/sse_pkg.sv =====
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types and constants of the sprite scanline evaluation block.
// ----------------------------------------------------------------------------
package sse_pkg;

   localparam int MEM_AW    = 8;
   localparam int MEM_DEPTH = 256;
   localparam int BYTE_W    = 8;

   localparam logic [MEM_AW-1:0] MEM_LAST_ADDR = 8'hFF;

   localparam logic [8:0] SHORT_HEIGHT = 9'd8;
   localparam logic [8:0] TALL_HEIGHT  = 9'd16;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   typedef struct packed {
      logic       opcode;
      logic [7:0] byte_addr;
      logic [7:0] byte_value;
      logic [7:0] line;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [7:0] top_row;
      logic [7:0] tile_index;
      logic [7:0] attributes;
      logic [7:0] left_column;
      logic       overflow;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FETCH
   } state_type;

endpackage

// ===== hdl/sse_ram.sv =====
// ----------------------------------------------------------------------------
// sse_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/sse_ctrl.sv =====
// ----------------------------------------------------------------------------
// sse_ctrl
// Sequencer: memory clear, byte writes, entry scan, sprite fetch and the
// result register.
// ----------------------------------------------------------------------------
module sse_ctrl
   import sse_pkg::*;
#(
   parameter int SPRITE_ENTRIES = 64,
   parameter int MAX_PER_LINE   = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              tall_sprites,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   output logic              mem_we,
   output logic [MEM_AW-1:0] mem_waddr,
   output logic [BYTE_W-1:0] mem_wdata,
   output logic [MEM_AW-1:0] mem_raddr,
   input  logic [BYTE_W-1:0] mem_rdata
);

   localparam int EW = $clog2(SPRITE_ENTRIES);
   localparam int CW = $clog2(MAX_PER_LINE + 1);
   localparam int LW = (MAX_PER_LINE > 1) ? $clog2(MAX_PER_LINE) : 1;

   state_type               state_ff, state_in;
   logic [MEM_AW-1:0]       clr_cnt_ff, clr_cnt_in;
   logic [7:0]              line_ff, line_in;
   logic [EW:0]             scan_cnt_ff, scan_cnt_in;
   logic                    chk_vld_ff, chk_vld_in;
   logic [EW-1:0]           chk_idx_ff, chk_idx_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    ovf_ff, ovf_in;
   logic [EW-1:0]           list_ff [MAX_PER_LINE];
   logic [EW-1:0]           list_in [MAX_PER_LINE];
   logic [CW-1:0]           emit_ff, emit_in;
   logic [2:0]              fc_ff, fc_in;
   logic [3:0][BYTE_W-1:0]  stage_ff, stage_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic       issue;
   logic       hit;
   logic       out_free;
   logic       is_last;
   logic       list_full;
   logic [8:0] height;
   logic [8:0] top9;
   logic [8:0] line9;

   assign height    = tall_sprites ? TALL_HEIGHT : SHORT_HEIGHT;
   assign top9      = {1'b0, mem_rdata};
   assign line9     = {1'b0, line_ff};
   assign issue     = scan_cnt_ff < (EW+1)'(SPRITE_ENTRIES);
   assign hit       = chk_vld_ff && (line9 >= top9) && (line9 < top9 + height);
   assign list_full = count_ff == CW'(MAX_PER_LINE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_last   = ({1'b0, emit_ff} + (CW+1)'(1)) == {1'b0, count_ff};

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      line_in      = line_ff;
      scan_cnt_in  = scan_cnt_ff;
      chk_vld_in   = chk_vld_ff;
      chk_idx_in   = chk_idx_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      list_in      = list_ff;
      emit_in      = emit_ff;
      fc_in        = fc_ff;
      stage_in     = stage_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_raddr    = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + MEM_AW'(1);
            if (clr_cnt_ff == MEM_LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_data.opcode == OP_WRITE) begin
                  mem_we    = 1'b1;
                  mem_waddr = req_data.byte_addr;
                  mem_wdata = req_data.byte_value;
               end else begin
                  line_in     = req_data.line;
                  scan_cnt_in = '0;
                  chk_vld_in  = 1'b0;
                  count_in    = '0;
                  ovf_in      = 1'b0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // read entry n while checking entry n-1
            mem_raddr  = MEM_AW'({scan_cnt_ff[EW-1:0], 2'b00});
            chk_vld_in = issue;
            chk_idx_in = scan_cnt_ff[EW-1:0];
            if (issue) begin
               scan_cnt_in = scan_cnt_ff + (EW+1)'(1);
            end
            if (hit && list_full) begin
               ovf_in   = 1'b1;
               emit_in  = '0;
               fc_in    = '0;
               state_in = ST_FETCH;
            end else if (hit) begin
               list_in[count_ff[LW-1:0]] = chk_idx_ff;
               count_in = count_ff + CW'(1);
            end else if (!issue && !chk_vld_ff) begin
               emit_in  = '0;
               fc_in    = '0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (count_ff == '0) begin
               if (out_free) begin
                  rsp_valid_in      = 1'b1;
                  rsp_data_in       = '0;
                  rsp_data_in.last  = 1'b1;
                  state_in          = ST_IDLE;
               end
            end else begin
               // four byte reads, then hand over to the result register
               mem_raddr = MEM_AW'({list_ff[emit_ff[LW-1:0]], fc_ff[1:0]});
               if (fc_ff < 3'd5) begin
                  fc_in = fc_ff + 3'd1;
               end
               if (fc_ff >= 3'd1 && fc_ff <= 3'd4) begin
                  stage_in[2'(fc_ff - 3'd1)] = mem_rdata;
               end
               if (fc_ff == 3'd5 && out_free) begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.found        = 1'b1;
                  rsp_data_in.top_row      = stage_ff[0];
                  rsp_data_in.tile_index   = stage_ff[1];
                  rsp_data_in.attributes   = stage_ff[2];
                  rsp_data_in.left_column  = stage_ff[3];
                  rsp_data_in.overflow     = is_last && ovf_ff;
                  rsp_data_in.last         = is_last;
                  if (is_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     emit_in = emit_ff + CW'(1);
                     fc_in   = '0;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         chk_vld_ff   <= 1'b0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         chk_vld_ff   <= chk_vld_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff     <= line_in;
      scan_cnt_ff <= scan_cnt_in;
      chk_idx_ff  <= chk_idx_in;
      list_ff     <= list_in;
      emit_ff     <= emit_in;
      fc_ff       <= fc_in;
      stage_ff    <= stage_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/sprite_scanline_evaluation.sv =====
// ----------------------------------------------------------------------------
// sprite_scanline_evaluation
// Sprite attribute memory with per-scanline selection of up to
// MAX_PER_LINE sprites and an overflow flag.
// ----------------------------------------------------------------------------
// write item: written straight into the attribute memory, no result
// evaluate item: a scan with one attribute memory read per entry (fewer when
//   an overflow match ends it), then four byte reads per result, or one
//   empty result when nothing matches; no new item is taken meanwhile
// the single memory read port serves both the scan and the result fetches
// reset: sync, clears the 256-byte memory, req_ready low meanwhile;
//   tall_sprites resets to 0
// ----------------------------------------------------------------------------
module sprite_scanline_evaluation
   import sse_pkg::*;
#(
   parameter int SPRITE_ENTRIES = 64,
   parameter int MAX_PER_LINE   = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   logic              tall_sprites_ff, tall_sprites_in;
   logic              mem_we;
   logic [MEM_AW-1:0] mem_waddr;
   logic [BYTE_W-1:0] mem_wdata;
   logic [MEM_AW-1:0] mem_raddr;
   logic [BYTE_W-1:0] mem_rdata;

   assign csr_ready       = 1'b1;
   assign tall_sprites_in = (csr_valid && csr_ready) ? csr_data : tall_sprites_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tall_sprites_ff <= 1'b0;
      end else begin
         tall_sprites_ff <= tall_sprites_in;
      end
   end

   sse_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MEM_DEPTH)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   sse_ctrl #(
      .SPRITE_ENTRIES (SPRITE_ENTRIES),
      .MAX_PER_LINE   (MAX_PER_LINE)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .tall_sprites (tall_sprites_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_raddr    (mem_raddr),
      .mem_rdata    (mem_rdata)
   );

   // overflow only on the final item of an evaluation
   a_ovf_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |-> rsp_data.last)
      else $error("overflow on a non-final item");

   // an empty item closes the evaluation and carries nothing else
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         rsp_data.last && !rsp_data.overflow && rsp_data.top_row == 8'h00 &&
         rsp_data.left_column == 8'h00)
      else $error("malformed empty item");

   // memory clear holds off input items right after reset
   a_clear: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("input taken during memory clear");

endmodule

// ===== dv/sprite_scanline_evaluation_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_scanline_evaluation_test
// Self-checking bench for the sprite scanline evaluation block. A short table
// of attribute writes and scanline evaluations comes first, then random phases
// under both sprite heights. Every result is checked field by field against
// the table row or an in-bench model of attribute memory and per-line selection.
// ----------------------------------------------------------------------------
module sprite_scanline_evaluation_test;
   import sse_pkg::*;

   localparam int SPRITES       = 64;
   localparam int PER_LINE      = 8;
   localparam int PW            = $clog2(PER_LINE);
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES   = 100;
   localparam int PHASE_ITEMS   = 25;

   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
   } probe_row;

   localparam rsp_type NO_RSP    = '0;
   localparam rsp_type EMPTY_END = '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1};

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_data;

   logic [7:0] sprite_bytes [256];
   logic       tall_mode;
   rsp_type    sprites_due [$];
   int         errors      = 0;
   int         cycle_count = 0;
   int         rsp_hold    = 0;
   bit         steady      = 1'b0;
   logic [7:0] shared_hot;

   probe_row probes [14] = '{
      '{'{OP_EVAL,  8'hFF, 8'hFF, 8'd255}, 1'b1, EMPTY_END},
      '{'{OP_EVAL,  8'h00, 8'h00, 8'd8},   1'b1, EMPTY_END},
      '{'{OP_EVAL,  8'hFF, 8'h00, 8'd0},   1'b0, NO_RSP},
      '{'{OP_EVAL,  8'h00, 8'hFF, 8'd7},   1'b0, NO_RSP},
      '{'{OP_WRITE, 8'h00, 8'hF8, 8'hFF},  1'b0, NO_RSP},
      '{'{OP_WRITE, 8'hFF, 8'hFF, 8'h00},  1'b0, NO_RSP},
      '{'{OP_EVAL,  8'h00, 8'h00, 8'd255}, 1'b1,
        '{1'b1, 8'hF8, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
      '{'{OP_WRITE, 8'h01, 8'hA5, 8'h00},  1'b0, NO_RSP},
      '{'{OP_WRITE, 8'h02, 8'h5A, 8'h00},  1'b0, NO_RSP},
      '{'{OP_WRITE, 8'h03, 8'hFF, 8'h00},  1'b0, NO_RSP},
      '{'{OP_EVAL,  8'h00, 8'h00, 8'd248}, 1'b1,
        '{1'b1, 8'hF8, 8'hA5, 8'h5A, 8'hFF, 1'b0, 1'b1}},
      '{'{OP_WRITE, 8'hFC, 8'hF0, 8'h00},  1'b0, NO_RSP},
      '{'{OP_EVAL,  8'h00, 8'h00, 8'd247}, 1'b1,
        '{1'b1, 8'hF0, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b1}},
      '{'{OP_EVAL,  8'h00, 8'h00, 8'd3},   1'b0, NO_RSP}
   };

   sprite_scanline_evaluation #(
      .SPRITE_ENTRIES(SPRITES),
      .MAX_PER_LINE  (PER_LINE)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   always #6 clock = ~clock;

   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(99);
      if (steady || roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void predict_item(input req_type r);
      int      hits;
      int      top;
      int      height;
      int      picked [PER_LINE];
      int      base;
      bit      spill;
      rsp_type res;
      hits  = 0;
      spill = 1'b0;
      if (r.opcode == OP_WRITE) begin
         sprite_bytes[r.byte_addr] = r.byte_value;
         return;
      end
      height = tall_mode ? int'(TALL_HEIGHT) : int'(SHORT_HEIGHT);
      for (int e = 0; e < SPRITES; e++) begin
         top = int'(sprite_bytes[8'(e*4)]);
         if (int'(r.line) >= top && int'(r.line) < top + height) begin
            if (hits == PER_LINE) begin
               spill = 1'b1;
               break;
            end
            picked[PW'(hits)] = e;
            hits++;
         end
      end
      if (hits == 0) begin
         sprites_due.push_back(EMPTY_END);
         return;
      end
      for (int k = 0; k < hits; k++) begin
         base            = picked[PW'(k)] * 4;
         res.found       = 1'b1;
         res.top_row     = sprite_bytes[8'(base)];
         res.tile_index  = sprite_bytes[8'(base + 1)];
         res.attributes  = sprite_bytes[8'(base + 2)];
         res.left_column = sprite_bytes[8'(base + 3)];
         res.overflow    = spill && (k == hits - 1);
         res.last        = (k == hits - 1);
         sprites_due.push_back(res);
      end
   endfunction

   // writes lean on top bytes near a hot line so that lines crowd and overflow
   function automatic req_type random_item(input logic [7:0] hot);
      req_type r;
      r = req_type'($urandom);
      if ($urandom_range(99) < 55) begin
         r.opcode = OP_WRITE;
         if ($urandom_range(1) == 1) begin
            r.byte_addr[1:0] = 2'b00;
            if ($urandom_range(2) != 0) r.byte_value = hot - 8'($urandom_range(15));
         end
      end else begin
         r.opcode = OP_EVAL;
         if ($urandom_range(3) != 0) r.line = hot + 8'($urandom_range(7));
      end
      return r;
   endfunction

   task automatic check_field(input string what, input logic [7:0] want_v,
                              input logic [7:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
         errors++;
      end
   endtask

   task automatic check_rsp(input rsp_type got);
      rsp_type want;
      if (sprites_due.size() == 0) begin
         $display("%0t: unexpected item, expected none, actual %h", $time, got);
         errors++;
         return;
      end
      want = sprites_due.pop_front();
      check_field("found",       8'(want.found),    8'(got.found));
      check_field("top_row",     want.top_row,      got.top_row);
      check_field("tile_index",  want.tile_index,   got.tile_index);
      check_field("attributes",  want.attributes,   got.attributes);
      check_field("left_column", want.left_column,  got.left_column);
      check_field("overflow",    8'(want.overflow), 8'(got.overflow));
      check_field("last",        8'(want.last),     8'(got.last));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_rsp(rsp_data);
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
         rsp_hold = draw_gap();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sprite_scanline_evaluation test failed");
         $finish;
      end
   end

   task automatic send_item(input req_type r, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic await_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sprites_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_tall(input logic v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tall_mode = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic tall, input logic [7:0] hot, input bit calm);
      req_type r;
      write_tall(tall);
      steady = calm;
      repeat (PHASE_ITEMS) begin
         r = random_item(hot);
         send_item(r, draw_gap());
         predict_item(r);
      end
      await_idle();
      steady = 1'b0;
   endtask

   initial begin
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = 1'b0;
      tall_mode = 1'b0;
      foreach (sprite_bytes[i]) sprite_bytes[i] = 8'h00;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_tall(1'b0);
      foreach (probes[i]) begin
         send_item(probes[i].item, draw_gap());
         if (probes[i].typed) sprites_due.push_back(probes[i].want);
         else predict_item(probes[i].item);
      end
      await_idle();

      shared_hot = 8'($urandom);
      run_phase(1'b1, 8'($urandom_range(0, 20)), 1'b0);
      run_phase(1'b0, shared_hot, 1'b0);
      run_phase(1'b1, shared_hot, 1'b1);
      run_phase(1'b0, 8'($urandom_range(240, 255)), 1'b0);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("sprite_scanline_evaluation test passed");
      end else begin
         $display("sprite_scanline_evaluation test failed");
      end
      $finish;
   end

endmodule
